FILE: rtl/ntbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ntbs_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 275;

    localparam int unsigned QM_W    = 4;
    localparam int unsigned NPRB_W  = 9;
    localparam int unsigned RATE_W  = 10;
    localparam int unsigned TBS_W   = 19;
    localparam int unsigned P1_W    = 13;
    localparam int unsigned NINFO_W = 20;
    localparam int unsigned LG_W    = 5;
    localparam int unsigned ND_W    = 21;
    localparam int unsigned SMALL_W = 12;
    localparam int unsigned C_W     = 9;
    localparam int unsigned D_W     = 12;
    localparam int unsigned Q_W     = 11;
    localparam int unsigned REM_W   = 22;
    localparam int unsigned TIDX_W  = 7;

    localparam int unsigned RE_PER_BLOCK = 156;
    localparam int unsigned SMALL_LIMIT  = 3824;
    localparam int unsigned LARGE_FLOOR  = 3840;
    localparam int unsigned SMALL_FLOOR  = 24;
    localparam int unsigned CRC_BITS     = 24;
    localparam int unsigned CB_LOW_RATE  = 3816;
    localparam int unsigned CB_HIGH_RATE = 8424;
    localparam int unsigned QUARTER_RATE = 256;
    localparam int unsigned TBS_MAX      = 524287;
    localparam int unsigned TABLE_LEN    = 93;

    // ceil(2^32 / K) for the two code block limits
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_LOW   = 1125516;
    localparam int unsigned RECIP_HIGH  = 509849;

    localparam int unsigned MID_DEPTH = 8;
    localparam int unsigned OUT_DEPTH = 16;
    localparam int unsigned MID_CNT_W = 4;
    localparam int unsigned OUT_CNT_W = 5;

    typedef struct packed {
        logic            is_small;
        logic            rate_low;
        logic [ND_W-1:0] nd;
    } t_mid;

    function automatic logic [SMALL_W-1:0] size_entry(input logic [TIDX_W-1:0] idx);
        logic [SMALL_W-1:0] v;
        unique case (idx)
            7'd0:  v = 12'd24;   7'd1:  v = 12'd32;   7'd2:  v = 12'd40;
            7'd3:  v = 12'd48;   7'd4:  v = 12'd56;   7'd5:  v = 12'd64;
            7'd6:  v = 12'd72;   7'd7:  v = 12'd80;   7'd8:  v = 12'd88;
            7'd9:  v = 12'd96;   7'd10: v = 12'd104;  7'd11: v = 12'd112;
            7'd12: v = 12'd120;  7'd13: v = 12'd128;  7'd14: v = 12'd136;
            7'd15: v = 12'd144;  7'd16: v = 12'd152;  7'd17: v = 12'd160;
            7'd18: v = 12'd168;  7'd19: v = 12'd176;  7'd20: v = 12'd184;
            7'd21: v = 12'd192;  7'd22: v = 12'd208;  7'd23: v = 12'd224;
            7'd24: v = 12'd240;  7'd25: v = 12'd256;  7'd26: v = 12'd272;
            7'd27: v = 12'd288;  7'd28: v = 12'd304;  7'd29: v = 12'd320;
            7'd30: v = 12'd336;  7'd31: v = 12'd352;  7'd32: v = 12'd368;
            7'd33: v = 12'd384;  7'd34: v = 12'd408;  7'd35: v = 12'd432;
            7'd36: v = 12'd456;  7'd37: v = 12'd480;  7'd38: v = 12'd504;
            7'd39: v = 12'd528;  7'd40: v = 12'd552;  7'd41: v = 12'd576;
            7'd42: v = 12'd608;  7'd43: v = 12'd640;  7'd44: v = 12'd672;
            7'd45: v = 12'd704;  7'd46: v = 12'd736;  7'd47: v = 12'd768;
            7'd48: v = 12'd808;  7'd49: v = 12'd848;  7'd50: v = 12'd888;
            7'd51: v = 12'd928;  7'd52: v = 12'd984;  7'd53: v = 12'd1032;
            7'd54: v = 12'd1064; 7'd55: v = 12'd1128; 7'd56: v = 12'd1160;
            7'd57: v = 12'd1192; 7'd58: v = 12'd1224; 7'd59: v = 12'd1256;
            7'd60: v = 12'd1288; 7'd61: v = 12'd1320; 7'd62: v = 12'd1352;
            7'd63: v = 12'd1416; 7'd64: v = 12'd1480; 7'd65: v = 12'd1544;
            7'd66: v = 12'd1608; 7'd67: v = 12'd1672; 7'd68: v = 12'd1736;
            7'd69: v = 12'd1800; 7'd70: v = 12'd1864; 7'd71: v = 12'd1928;
            7'd72: v = 12'd2024; 7'd73: v = 12'd2088; 7'd74: v = 12'd2152;
            7'd75: v = 12'd2216; 7'd76: v = 12'd2280; 7'd77: v = 12'd2408;
            7'd78: v = 12'd2472; 7'd79: v = 12'd2536; 7'd80: v = 12'd2600;
            7'd81: v = 12'd2664; 7'd82: v = 12'd2728; 7'd83: v = 12'd2792;
            7'd84: v = 12'd2856; 7'd85: v = 12'd2976; 7'd86: v = 12'd3104;
            7'd87: v = 12'd3240; 7'd88: v = 12'd3368; 7'd89: v = 12'd3496;
            7'd90: v = 12'd3624; 7'd91: v = 12'd3752; 7'd92: v = 12'd3824;
            default: v = 12'd3824;
        endcase
        return v;
    endfunction

    // first table entry not below nd
    function automatic logic [SMALL_W-1:0] size_lookup(input logic [SMALL_W-1:0] nd);
        logic [SMALL_W-1:0] r;
        logic [SMALL_W-1:0] e;
        r = SMALL_W'(SMALL_LIMIT);
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            e = size_entry(TIDX_W'(i));
            if (e >= nd) begin
                r = e;
            end
        end
        return r;
    endfunction

    function automatic logic [LG_W-1:0] lead_one(input logic [NINFO_W-1:0] v);
        logic [LG_W-1:0] p;
        p = '0;
        for (int i = 0; i < NINFO_W; i++) begin
            if (v[i]) begin
                p = LG_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ntbs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ntbs_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic      [WIDTH-1:0]               o_data,
    output logic                                o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

`default_nettype wire

FILE: rtl/ntbs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ntbs_front #(
    parameter int unsigned MAX_BLOCKS = ntbs_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [ntbs_pkg::QM_W-1:0]     i_bits_per_symbol,
    input  wire logic [ntbs_pkg::NPRB_W-1:0]   i_num_blocks,
    input  wire logic [ntbs_pkg::RATE_W-1:0]   i_rate_x1024,
    output logic                               o_valid,
    output ntbs_pkg::t_mid                     o_item
);
    import ntbs_pkg::*;

    logic [4:0] r_v;

    logic [P1_W-1:0]    r_p1;
    logic [RATE_W-1:0]  r_rate1, r_rate2;
    logic [3:0]         r_rl;
    logic [NINFO_W-1:0] r_p2;
    logic [NINFO_W-1:0] r_ninfo;
    logic [NINFO_W-1:0] r_val4;
    logic [LG_W-1:0]    r_lg4;
    logic               r_sm4;
    t_mid               r_item;

    logic [NPRB_W-1:0]       nprb_sat;
    logic [2*NINFO_W-11:0]   prod3;
    logic                    sm;
    logic [NINFO_W-1:0]      val;
    logic [LG_W-1:0]         sh_s, sh_l;
    logic [NINFO_W-1:0]      nd_s;
    logic [ND_W-1:0]         sum_l, nd_l;
    t_mid                    item5;

    assign nprb_sat = (i_num_blocks > NPRB_W'(MAX_BLOCKS)) ? NPRB_W'(MAX_BLOCKS) : i_num_blocks;
    assign prod3    = (2*NINFO_W-10)'(r_p2) * (2*NINFO_W-10)'(r_rate2);
    assign sm       = (r_ninfo <= NINFO_W'(SMALL_LIMIT));
    assign val      = sm ? r_ninfo : r_ninfo - NINFO_W'(CRC_BITS);

    always_comb begin
        // small branch: truncate to a multiple of 2^n
        sh_s = ((r_val4 == '0) || (r_lg4 < LG_W'(9))) ? LG_W'(3) : r_lg4 - LG_W'(6);
        nd_s = (r_val4 >> sh_s) << sh_s;
        if (nd_s < NINFO_W'(SMALL_FLOOR)) begin
            nd_s = NINFO_W'(SMALL_FLOOR);
        end
        // large branch: round half up to a multiple of 2^n
        sh_l  = r_lg4 - LG_W'(5);
        sum_l = ND_W'(r_val4) + (ND_W'(1) << (sh_l - 1'b1));
        nd_l  = (sum_l >> sh_l) << sh_l;
        if (nd_l < ND_W'(LARGE_FLOOR)) begin
            nd_l = ND_W'(LARGE_FLOOR);
        end
        item5.is_small = r_sm4;
        item5.rate_low = r_rl[3];
        item5.nd       = r_sm4 ? ND_W'(nd_s) : nd_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= P1_W'(i_bits_per_symbol) * P1_W'(nprb_sat);
        r_rate1 <= i_rate_x1024;
        r_rl    <= {r_rl[2:0], (i_rate_x1024 <= RATE_W'(QUARTER_RATE))};
        r_p2    <= NINFO_W'(r_p1) * NINFO_W'(RE_PER_BLOCK);
        r_rate2 <= r_rate1;
        r_ninfo <= prod3[2*NINFO_W-11:10];
        r_sm4   <= sm;
        r_val4  <= val;
        r_lg4   <= lead_one(val);
        r_item  <= item5;
    end

    assign o_valid = r_v[4];
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/ntbs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ntbs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire ntbs_pkg::t_mid                i_item,
    output logic                               o_valid,
    output logic [ntbs_pkg::TBS_W-1:0]         o_tbs
);
    import ntbs_pkg::*;

    localparam int unsigned PROD_W = 2 * ND_W;
    localparam int unsigned FIN_W  = Q_W + C_W + 3;

    logic [ND_W-1:0]    x, k_sel, y;
    logic [PROD_W-1:0]  recip, prod1;

    logic               r_v1;
    logic [C_W-1:0]     r_cq1;
    logic [ND_W-1:0]    r_x1;
    logic               r_big1, r_rl1, r_sm1;
    logic [SMALL_W-1:0] r_ts1;

    logic [C_W-1:0]     cb;
    logic [D_W-1:0]     dv;

    // divider stages, index 0 is the output of the code block stage
    logic [Q_W:0]       r_v;
    logic [REM_W-1:0]   r_rem [Q_W+1];
    logic [Q_W-1:0]     r_q   [Q_W+1];
    logic [D_W-1:0]     r_d   [Q_W+1];
    logic [C_W-1:0]     r_c   [Q_W+1];
    logic               r_sm  [Q_W+1];
    logic [SMALL_W-1:0] r_ts  [Q_W+1];

    logic [FIN_W-1:0]   fin;
    logic               r_vo;
    logic [TBS_W-1:0]   r_tbs;

    assign x     = i_item.nd + ND_W'(CRC_BITS);
    assign k_sel = i_item.rate_low ? ND_W'(CB_LOW_RATE) : ND_W'(CB_HIGH_RATE);
    assign recip = i_item.rate_low ? PROD_W'(RECIP_LOW) : PROD_W'(RECIP_HIGH);
    assign y     = x + k_sel - 1'b1;
    assign prod1 = PROD_W'(y) * recip;

    always_ff @(posedge i_clk) begin
        r_cq1  <= C_W'(prod1 >> RECIP_SHIFT);
        r_x1   <= x;
        r_big1 <= (i_item.nd > ND_W'(CB_HIGH_RATE));
        r_rl1  <= i_item.rate_low;
        r_sm1  <= i_item.is_small;
        r_ts1  <= size_lookup(i_item.nd[SMALL_W-1:0]);
    end

    assign cb = (r_rl1 || r_big1) ? r_cq1 : C_W'(1);
    assign dv = {cb, 3'b000};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_W'(r_x1) + REM_W'(dv) - 1'b1;
        r_q[0]   <= '0;
        r_d[0]   <= dv;
        r_c[0]   <= cb;
        r_sm[0]  <= r_sm1;
        r_ts[0]  <= r_ts1;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [REM_W-1:0] dsh;
        logic             ge;
        assign dsh = REM_W'(r_d[k]) << (Q_W - 1 - k);
        assign ge  = (r_rem[k] >= dsh);
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? r_rem[k] - dsh : r_rem[k];
            r_q[k+1]   <= {r_q[k][Q_W-2:0], ge};
            r_d[k+1]   <= r_d[k];
            r_c[k+1]   <= r_c[k];
            r_sm[k+1]  <= r_sm[k];
            r_ts[k+1]  <= r_ts[k];
        end
    end

    // round up to a multiple of 8C, then drop the CRC
    assign fin = {(FIN_W-3)'(r_q[Q_W]) * (FIN_W-3)'(r_c[Q_W]), 3'b000}
                 - FIN_W'(CRC_BITS);

    always_ff @(posedge i_clk) begin
        if (r_sm[Q_W]) begin
            r_tbs <= TBS_W'(r_ts[Q_W]);
        end else if (fin > FIN_W'(TBS_MAX)) begin
            r_tbs <= TBS_W'(TBS_MAX);
        end else begin
            r_tbs <= TBS_W'(fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v  <= {r_v[Q_W-1:0], r_v1};
            r_vo <= r_v[Q_W];
        end
    end

    assign o_valid = r_vo;
    assign o_tbs   = r_tbs;

endmodule

`default_nettype wire

FILE: rtl/nr_transport_block_size_core.sv
// NR transport block size calculator.
// Input queue side: drive i_bits_per_symbol, i_num_blocks and i_rate_x1024 with push;
// an item is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low, o_tbs holds the oldest result; pop takes it.
// Path: the front part (resource product and Ninfo quantisation), the middle
// queue, the back part (code block count by reciprocal multiply, 11-stage
// restoring divider for the 8C rounding, final multiply), then the result
// queue.
// Throughput: one item per cycle while full stays low and pop keeps up, set by
// the fully pipelined front and back parts; the middle queue (8 entries) and
// result queue (16 entries) are sized to cover the pipeline depths with credit
// counting.
// When pop is held low the result queue fills, the back part stops drawing from
// the middle queue, and full rises once the front credits run out; nothing in
// the pipelines ever stalls mid-flight.
// Reset (synchronous, active low) empties both queues and drops items in flight.
`timescale 1ns / 1ps
`default_nettype none

module nr_transport_block_size_core #(
    parameter int unsigned MAX_BLOCKS = ntbs_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [ntbs_pkg::QM_W-1:0]     i_bits_per_symbol,
    input  wire logic [ntbs_pkg::NPRB_W-1:0]   i_num_blocks,
    input  wire logic [ntbs_pkg::RATE_W-1:0]   i_rate_x1024,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [ntbs_pkg::TBS_W-1:0]         o_tbs
);
    import ntbs_pkg::*;

    logic                 accept;
    logic                 front_valid;
    t_mid                 front_item;
    logic [$bits(t_mid)-1:0] mid_rd_data;
    t_mid                 mid_item;
    logic                 mid_empty;
    logic [MID_CNT_W-1:0] mid_cnt;
    logic                 issue;
    logic                 back_valid;
    logic [TBS_W-1:0]     back_tbs;
    logic [OUT_CNT_W-1:0] out_cnt;
    logic                 out_pop;

    logic [MID_CNT_W-1:0] r_fcnt, n_fcnt;
    logic [OUT_CNT_W-1:0] r_bcnt, n_bcnt;

    assign full    = ((MID_CNT_W+1)'(r_fcnt) + (MID_CNT_W+1)'(mid_cnt))
                     >= (MID_CNT_W+1)'(MID_DEPTH);
    assign accept  = push && !full;
    assign issue   = !mid_empty &&
                     (((OUT_CNT_W+1)'(r_bcnt) + (OUT_CNT_W+1)'(out_cnt))
                      < (OUT_CNT_W+1)'(OUT_DEPTH));
    assign out_pop = pop && !empty;
    assign mid_item = t_mid'(mid_rd_data);

    always_comb begin
        n_fcnt = r_fcnt + MID_CNT_W'(accept) - MID_CNT_W'(front_valid);
        n_bcnt = r_bcnt + OUT_CNT_W'(issue) - OUT_CNT_W'(back_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_bcnt <= '0;
        end else begin
            r_fcnt <= n_fcnt;
            r_bcnt <= n_bcnt;
        end
    end

    ntbs_front #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (accept),
        .i_bits_per_symbol(i_bits_per_symbol),
        .i_num_blocks     (i_num_blocks),
        .i_rate_x1024     (i_rate_x1024),
        .o_valid          (front_valid),
        .o_item           (front_item)
    );

    ntbs_fifo #(
        .WIDTH($bits(t_mid)),
        .DEPTH(MID_DEPTH)
    ) u_mid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_valid),
        .i_data (front_item),
        .i_pop  (issue),
        .o_data (mid_rd_data),
        .o_empty(mid_empty),
        .o_count(mid_cnt)
    );

    ntbs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(issue),
        .i_item (mid_item),
        .o_valid(back_valid),
        .o_tbs  (back_tbs)
    );

    ntbs_fifo #(
        .WIDTH(TBS_W),
        .DEPTH(OUT_DEPTH)
    ) u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_valid),
        .i_data (back_tbs),
        .i_pop  (out_pop),
        .o_data (o_tbs),
        .o_empty(empty),
        .o_count(out_cnt)
    );

    a_mid_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> (mid_cnt < MID_CNT_W'(MID_DEPTH)))
        else $error("middle queue written while full");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_valid |-> (out_cnt < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue written while full");

    a_front_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> (r_fcnt != '0))
        else $error("front output without outstanding credit");

    a_back_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (r_bcnt != '0))
        else $error("back issue not counted");

endmodule

`default_nettype wire
